>>> hdl/spims_pkg.sv
package spims_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_SCK_RATE_CODE  = 2'd0;
   localparam logic [1:0] CSR_CLOCK_POLARITY = 2'd1;
   localparam logic [1:0] CSR_MASTER_ENABLE  = 2'd2;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 3;
   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned RSP_TDATA_W = 16;
   localparam int unsigned RESULT_W    = 13;

   // reset values of the configuration registers
   localparam logic [2:0] RATE_CODE_RESET = 3'd3;
   localparam logic       POLARITY_RESET  = 1'b0;
   localparam logic       ENABLE_RESET    = 1'b1;

   typedef struct packed {
      logic [2:0] sck_rate_code;
      logic       clock_polarity;
      logic       master_enable;
   } csr_type;

   // one result item, sck in the lowest bit
   typedef struct packed {
      logic       write_collision;
      logic [7:0] rx_byte;
      logic       transfer_done;
      logic       busy_res;
      logic       mosi;
      logic       sck;
   } result_type;

   // serial clock half period in ticks (accepted input transactions), by rate code
   function automatic logic [6:0] half_period(input logic [2:0] code);
      logic [6:0] ticks;
      case (code)
         3'd0: ticks = 7'd2;
         3'd1: ticks = 7'd8;
         3'd2: ticks = 7'd32;
         3'd3: ticks = 7'd64;
         3'd4: ticks = 7'd1;
         3'd5: ticks = 7'd4;
         3'd6: ticks = 7'd16;
         3'd7: ticks = 7'd32;
         default: ticks = 7'd64;
      endcase
      return ticks;
   endfunction

endpackage

>>> hdl/spims_core.sv
module spims_core
   import spims_pkg::*;
#(
   parameter int unsigned FRAME_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       action,
   input  logic [7:0] tx_byte,
   input  logic       miso,
   input  csr_type    csr,
   output result_type result_in
);

   localparam int unsigned BITS_W = $clog2(FRAME_BITS + 1);
   localparam logic [BITS_W-1:0] FRAME_COUNT = BITS_W'(FRAME_BITS);

   logic [FRAME_BITS-1:0] shift_ff,   shift_in;
   logic [BITS_W-1:0]     bits_ff,    bits_in;
   logic [6:0]            count_ff,   count_in;
   logic                  clk_ff,     clk_in;
   logic                  busy_ff,    busy_in;
   logic                  done_ff,    done_in;
   logic [7:0]            rx_ff,      rx_in;
   logic                  coll_ff,    coll_in;
   logic                  mosi_ff,    mosi_in;

   logic [FRAME_BITS-1:0] frame_load;
   logic [FRAME_BITS-1:0] shift_sampled;
   logic [7:0]            rx_sampled;
   logic [6:0]            count_inc;
   logic [BITS_W-1:0]     bits_dec;
   logic                  clk_toggled;

   // frame from the send byte, zero-extended or truncated to the frame length
   // and received bits taken into the low bits of the byte
   for (genvar i = 0; i < FRAME_BITS; i++) begin : g_load
      if (i < 8) begin : g_tx
         assign frame_load[i] = tx_byte[i];
      end else begin : g_zero
         assign frame_load[i] = 1'b0;
      end
   end

   assign shift_sampled = {shift_ff[FRAME_BITS-2:0], miso};

   for (genvar i = 0; i < 8; i++) begin : g_rx
      if (i < FRAME_BITS) begin : g_bit
         assign rx_sampled[i] = shift_sampled[i];
      end else begin : g_zero
         assign rx_sampled[i] = 1'b0;
      end
   end

   assign count_inc   = count_ff + 7'd1;
   assign bits_dec    = (bits_ff != '0) ? bits_ff - BITS_W'(1) : bits_ff;
   assign clk_toggled = ~clk_ff;

   // next state for one tick
   always_comb begin
      shift_in = shift_ff;
      bits_in  = bits_ff;
      count_in = count_ff;
      clk_in   = clk_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      rx_in    = rx_ff;
      coll_in  = coll_ff;
      mosi_in  = mosi_ff;
      if (!csr.master_enable) begin
         busy_in  = 1'b0;
         bits_in  = '0;
         count_in = '0;
         clk_in   = csr.clock_polarity;
      end else if (busy_ff) begin
         if (action) begin
            coll_in = 1'b1;
         end
         count_in = count_inc;
         if (count_inc >= half_period(csr.sck_rate_code)) begin
            count_in = '0;
            clk_in   = clk_toggled;
            if (clk_toggled != csr.clock_polarity) begin
               // leading edge: sample miso
               shift_in = shift_sampled;
               bits_in  = bits_dec;
               if (bits_dec == '0) begin
                  rx_in   = rx_sampled;
                  done_in = 1'b1;
               end
            end else begin
               // trailing edge: drive next bit or finish
               if (bits_ff == '0) begin
                  busy_in = 1'b0;
               end else begin
                  mosi_in = shift_ff[FRAME_BITS-1];
               end
            end
         end
      end else begin
         clk_in = csr.clock_polarity;
         if (action) begin
            shift_in = frame_load;
            mosi_in  = frame_load[FRAME_BITS-1];
            bits_in  = FRAME_COUNT;
            count_in = '0;
            busy_in  = 1'b1;
            done_in  = 1'b0;
            coll_in  = 1'b0;
         end
      end
   end

   // state registers, advanced once per input transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         bits_ff  <= '0;
         count_ff <= '0;
         clk_ff   <= POLARITY_RESET;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         rx_ff    <= '0;
         coll_ff  <= 1'b0;
         mosi_ff  <= 1'b0;
      end else if (step) begin
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         count_ff <= count_in;
         clk_ff   <= clk_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         rx_ff    <= rx_in;
         coll_ff  <= coll_in;
         mosi_ff  <= mosi_in;
      end
   end

   // result is the line state after this tick
   always_comb begin
      result_in.sck             = clk_in;
      result_in.mosi            = mosi_in;
      result_in.busy_res        = busy_in;
      result_in.transfer_done   = done_in;
      result_in.rx_byte         = rx_in;
      result_in.write_collision = coll_in;
   end

endmodule

>>> hdl/spi_master_byte_shifter.sv
// output: each result is registered and appears in the cycle after its input transaction is accepted
// throughput: one tick per cycle; req_tready stays high unless the output
//    register holds a result that rsp_tready has not taken
// reset: synchronous, active high; clears the shifter state, empties the output
//    register and loads rate code 3, polarity 0 and master enable 1
module spi_master_byte_shifter
   import spims_pkg::*;
#(
   parameter int unsigned FRAME_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // tx_byte[7:0], miso[8], zero pad
   input  logic                   req_tuser,  // action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // sck[0], mosi[1], busy_res[2], transfer_done[3], rx_byte[11:4],
   // write_collision[12], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_type    csr_ff;
   result_type result_in;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.sck_rate_code  <= RATE_CODE_RESET;
         csr_ff.clock_polarity <= POLARITY_RESET;
         csr_ff.master_enable  <= ENABLE_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SCK_RATE_CODE:  csr_ff.sck_rate_code  <= csr_wdata;
            CSR_CLOCK_POLARITY: csr_ff.clock_polarity <= csr_wdata[0];
            CSR_MASTER_ENABLE:  csr_ff.master_enable  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   spims_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .action    (req_tuser),
      .tx_byte   (req_tdata[7:0]),
      .miso      (req_tdata[8]),
      .csr       (csr_ff),
      .result_in (result_in)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RESULT_W)'(0), rsp_data_ff};

endmodule

>>> hdl/spims_checker.sv
module spims_checker
   import spims_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // output register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // every input transaction yields a result in the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("input transaction without result");

   // a stalled result blocks the input side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind spi_master_byte_shifter spims_checker u_spims_checker (.*);
